// File: rtl/core/skt_pkg.sv
package skt_pkg;

   localparam int KeyW = 64;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_MISS = 2'd1,
      ST_FULL = 2'd2
   } status_type;

   typedef enum logic {
      OP_SEARCH = 1'b0,
      OP_INSERT = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      WM_8  = 2'd0,
      WM_16 = 2'd1,
      WM_32 = 2'd2,
      WM_64 = 2'd3
   } wmode_type;

   typedef enum logic [1:0] {
      S_IDLE   = 2'd0,
      S_SEARCH = 2'd1,
      S_INSERT = 2'd2,
      S_DONE   = 2'd3
   } state_type;

   localparam logic CSR_KEY_WIDTH = 1'b0;
   localparam logic CSR_CAPACITY  = 1'b1;

   // broadcast from the controller to every cell
   typedef struct packed {
      logic            start;    // insert taken: the slot at count holds the hole
      logic            step;     // insert running: the hole walks down one slot a cycle
      logic [KeyW-1:0] key;      // truncated key
      logic [KeyW-1:0] mask;
   } cell_ctl_type;

   function automatic logic [KeyW-1:0] width_mask(input logic [1:0] mode);
      logic [KeyW-1:0] m;
      case (mode)
         WM_8:    m = 64'h0000_0000_0000_00FF;
         WM_16:   m = 64'h0000_0000_0000_FFFF;
         WM_32:   m = 64'h0000_0000_FFFF_FFFF;
         default: m = 64'hFFFF_FFFF_FFFF_FFFF;
      endcase
      return m;
   endfunction

endpackage

// File: rtl/core/skt_cell.sv
// One table slot. During an insert the slot holding the hole compares the
// key with its left neighbor: if the key is not strictly greater the
// neighbor's value moves up into this slot and the hole passes left,
// otherwise the key lands here.
module skt_cell (
   input  logic                     clock,
   input  skt_pkg::cell_ctl_type    ctl,
   input  logic                     at_count,     // this slot index == count
   input  logic                     has_left,     // a slot exists below this one
   input  logic                     token_down,   // the slot above passes the hole
   input  logic [skt_pkg::KeyW-1:0] left_value,   // left neighbor, truncated
   output logic                     pass_out,     // hole moves to the left neighbor
   output logic                     place_out,    // key lands here this cycle
   output logic [skt_pkg::KeyW-1:0] value
);

   logic [skt_pkg::KeyW-1:0] value_ff, value_in;
   logic                     tok_ff, tok_in;
   logic                     key_above;

   assign key_above = !has_left || (ctl.key > left_value);
   assign place_out = ctl.step && tok_ff && key_above;
   assign pass_out  = ctl.step && tok_ff && !key_above;

   always_comb begin
      value_in = value_ff;
      if (pass_out) begin
         value_in = left_value;
      end else if (place_out) begin
         value_in = ctl.key;
      end
   end

   assign tok_in = ctl.start ? at_count : token_down;

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      tok_ff   <= tok_in;
   end

   assign value = value_ff;

endmodule

// File: rtl/core/skt_row.sv
module skt_row #(
   parameter int DEPTH = 256,
   parameter int IW    = 8,
   parameter int CW    = 9
) (
   input  logic                     clock,
   input  skt_pkg::cell_ctl_type    ctl,
   input  logic [CW-1:0]            count,
   input  logic [IW-1:0]            probe_idx,
   output logic [skt_pkg::KeyW-1:0] probe_value,
   output logic                     placed
);

   logic [skt_pkg::KeyW-1:0] vals [DEPTH];
   logic [DEPTH-1:0]         passes;
   logic [DEPTH-1:0]         places;
   logic [skt_pkg::KeyW-1:0] probe_ff;

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic                     hasl;
      logic                     tdown;
      logic [skt_pkg::KeyW-1:0] lval;
      if (g == 0) begin : g_first
         assign hasl = 1'b0;
         assign lval = '0;
      end else begin : g_rest
         assign hasl = 1'b1;
         assign lval = vals[g-1] & ctl.mask;
      end
      if (g == DEPTH - 1) begin : g_top
         assign tdown = 1'b0;
      end else begin : g_below
         assign tdown = passes[g+1];
      end
      skt_cell u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .at_count    (CW'(g) == count),
         .has_left    (hasl),
         .token_down  (tdown),
         .left_value  (lval),
         .pass_out    (passes[g]),
         .place_out   (places[g]),
         .value       (vals[g])
      );
   end

   assign placed = |places;

   always_ff @(posedge clock) begin
      probe_ff <= vals[probe_idx];
   end

   assign probe_value = probe_ff;

endmodule

// File: rtl/core/sorted_key_table.sv
// Search: up to log2(DEPTH)+1 probes, each an address phase and a compare
// phase, plus a final check phase on a miss, then the result register
// loads. Insert: the hole walks down one cell a cycle to its slot; a full
// insert goes straight to the result. One item at a time: the next transfer
// in the cycle after the result register loads; a held result delays that.
// Synchronous active-high reset clears count, control and rsp_valid.
module sorted_key_table #(
   parameter int DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_op,
   input  logic [63:0] req_key,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_index,
   output logic [8:0]  rsp_entry_count,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [8:0]  csr_data
);

   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   skt_pkg::state_type state_ff, state_in;
   logic [1:0]  wmode_ff;
   logic [8:0]  cap_ff;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [CW-1:0] pos_ff, pos_in;
   logic        ph_ff, ph_in;
   logic        op_ff;
   logic [63:0] key_ff;
   logic [1:0]  st_ff, st_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic        rv_ff;
   logic [1:0]  out_st_ff;
   logic [7:0]  out_idx_ff;
   logic [8:0]  out_cnt_ff;

   logic [63:0] mask, probe_val;
   logic [CW-1:0] mid, cap_eff;
   logic        accept, has_room, ins_start, placed, out_free, done_now;
   skt_pkg::cell_ctl_type ctl;

   assign mask = skt_pkg::width_mask(wmode_ff);
   assign mid  = CW'(({1'b0, lo_ff} + {1'b0, hi_ff}) >> 1);
   assign cap_eff = ({23'd0, cap_ff} < 32'(DEPTH)) ? CW'(cap_ff) : CW'(DEPTH);

   assign req_stall = (state_ff != skt_pkg::S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign has_room  = (count_ff < cap_eff);
   assign ins_start = accept && (req_op == skt_pkg::OP_INSERT) && has_room;
   // result register can take a new result at this edge
   assign out_free  = !rv_ff || !rsp_stall;

   assign ctl.start = ins_start;
   assign ctl.step  = (state_ff == skt_pkg::S_INSERT);
   assign ctl.key   = key_ff;
   assign ctl.mask  = mask;

   skt_row #(.DEPTH(DEPTH), .IW(IW), .CW(CW)) u_row (
      .clock       (clock),
      .ctl         (ctl),
      .count       (count_ff),
      .probe_idx   (mid[IW-1:0]),
      .probe_value (probe_val),
      .placed      (placed)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         wmode_ff <= skt_pkg::WM_64;
         cap_ff   <= 9'd256;
      end else if (csr_write) begin
         case (csr_index)
            skt_pkg::CSR_KEY_WIDTH: wmode_ff <= csr_data[1:0];
            skt_pkg::CSR_CAPACITY:  cap_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // probe phase 0 presents the address, phase 1 compares the registered entry
   assign done_now = ph_ff ? (key_ff == (probe_val & mask)) : !(lo_ff < hi_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         skt_pkg::S_IDLE: begin
            if (accept) begin
               if (req_op == skt_pkg::OP_INSERT) begin
                  state_in = has_room ? skt_pkg::S_INSERT : skt_pkg::S_DONE;
               end else begin
                  state_in = skt_pkg::S_SEARCH;
               end
            end
         end
         skt_pkg::S_SEARCH: begin
            if (done_now) state_in = skt_pkg::S_DONE;
         end
         skt_pkg::S_INSERT: begin
            if (placed) state_in = skt_pkg::S_DONE;
         end
         skt_pkg::S_DONE: begin
            if (out_free) state_in = skt_pkg::S_IDLE;
         end
         default: state_in = skt_pkg::S_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      pos_in   = pos_ff;
      ph_in    = ph_ff;
      st_in    = st_ff;
      idx_in   = idx_ff;
      count_in = count_ff;
      case (state_ff)
         skt_pkg::S_IDLE: begin
            lo_in  = '0;
            hi_in  = count_ff;
            pos_in = count_ff;
            ph_in  = 1'b0;
            st_in  = skt_pkg::ST_FULL;
            idx_in = '0;
         end
         skt_pkg::S_SEARCH: begin
            if (!ph_ff) begin
               if (!(lo_ff < hi_ff)) begin
                  st_in  = skt_pkg::ST_MISS;
                  idx_in = '0;
               end else begin
                  ph_in = 1'b1;
               end
            end else if (key_ff == (probe_val & mask)) begin
               st_in  = skt_pkg::ST_OK;
               idx_in = mid;
            end else if (key_ff < (probe_val & mask)) begin
               hi_in = mid;
               ph_in = 1'b0;
            end else begin
               lo_in = mid + CW'(1);
               ph_in = 1'b0;
            end
         end
         skt_pkg::S_INSERT: begin
            if (placed) begin
               st_in    = skt_pkg::ST_OK;
               idx_in   = pos_ff;
               count_in = count_ff + CW'(1);
            end else begin
               pos_in = pos_ff - CW'(1);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= skt_pkg::S_IDLE;
         count_ff <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (state_ff == skt_pkg::S_DONE && out_free) begin
            rv_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rv_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      pos_ff <= pos_in;
      ph_ff  <= ph_in;
      st_ff  <= st_in;
      idx_ff <= idx_in;
      if (accept) begin
         op_ff  <= req_op;
         key_ff <= req_key & mask;
      end
      if (state_ff == skt_pkg::S_DONE && out_free) begin
         out_st_ff  <= st_ff;
         out_idx_ff <= (st_ff == skt_pkg::ST_OK) ? 8'(idx_ff) : 8'd0;
         out_cnt_ff <= 9'(count_ff);
      end
   end

   assign rsp_valid       = rv_ff;
   assign rsp_status      = out_st_ff;
   assign rsp_index       = out_idx_ff;
   assign rsp_entry_count = out_cnt_ff;

`ifndef SYNTHESIS
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("count exceeds depth");
   a_full_keeps: assert property (@(posedge clock) disable iff (reset)
      (state_ff == skt_pkg::S_DONE && st_ff == skt_pkg::ST_FULL) |-> $stable(count_ff))
      else $error("full insert changed count");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rv_ff && rsp_stall) |=> (rv_ff && $stable(out_st_ff) && $stable(out_idx_ff)
                                && $stable(out_cnt_ff)))
      else $error("stalled result changed");
   a_ins_op: assert property (@(posedge clock) disable iff (reset)
      state_ff == skt_pkg::S_INSERT |-> op_ff == skt_pkg::OP_INSERT)
      else $error("insert state without insert op");
`endif

endmodule

// File: test/sorted_key_table_tb.sv
module sorted_key_table_tb;

   class key_table_scoreboard;
      logic [63:0] table_keys [256];
      int unsigned num_keys;
      logic [1:0]  width_mode;
      int unsigned cap_limit;
      skt_pkg::status_type exp_status [$];
      logic [7:0]  exp_index [$];
      logic [8:0]  exp_count [$];
      int errors;
      int hits, misses, fulls, inserts;

      function void reset_state();
         num_keys = 0;
         width_mode = skt_pkg::WM_64;
         cap_limit = 256;
      endfunction

      function void write_reg(logic idx, logic [8:0] value);
         if (idx == skt_pkg::CSR_KEY_WIDTH) width_mode = value[1:0];
         else cap_limit = value;
      endfunction

      function logic [63:0] key_mask();
         case (width_mode)
            skt_pkg::WM_8:  return 64'hFF;
            skt_pkg::WM_16: return 64'hFFFF;
            skt_pkg::WM_32: return 64'hFFFF_FFFF;
            default:        return '1;
         endcase
      endfunction

      // accepted request: run the search or insert on the shadow table
      function void note_request(skt_pkg::op_type op, logic [63:0] key);
         logic [63:0] m, k, e;
         int unsigned lo, hi, mid, i, cap;
         skt_pkg::status_type st;
         int unsigned pos;
         m = key_mask();
         k = key & m;
         st = skt_pkg::ST_MISS;
         pos = 0;
         if (op == skt_pkg::OP_SEARCH) begin
            lo = 0;
            hi = num_keys;
            while (lo < hi) begin
               mid = (lo + hi) / 2;
               e = table_keys[mid] & m;
               if (k == e) begin
                  st = skt_pkg::ST_OK;
                  pos = mid;
                  break;
               end
               if (k < e) hi = mid;
               else lo = mid + 1;
            end
            if (st == skt_pkg::ST_OK) hits++;
            else misses++;
         end else begin
            cap = (cap_limit < 256) ? cap_limit : 256;
            if (num_keys + 1 > cap) begin
               st = skt_pkg::ST_FULL;
               fulls++;
            end else begin
               i = num_keys;
               while (i > 0) begin
                  e = table_keys[i-1] & m;
                  if (k > e) break;
                  table_keys[i] = e;
                  i--;
               end
               table_keys[i] = k;
               num_keys++;
               st = skt_pkg::ST_OK;
               pos = i;
               inserts++;
            end
         end
         exp_status.push_back(st);
         exp_index.push_back(pos[7:0]);
         exp_count.push_back(num_keys[8:0]);
      endfunction

      function void check_response(logic [1:0] status, logic [7:0] index, logic [8:0] cnt);
         logic [1:0] s;
         logic [7:0] x;
         logic [8:0] c;
         if (exp_status.size() == 0) begin
            $error("response with nothing pending: status %0d index %0d count %0d",
                   status, index, cnt);
            errors++;
            return;
         end
         s = exp_status.pop_front();
         x = exp_index.pop_front();
         c = exp_count.pop_front();
         if (status !== s) begin
            $error("status: expected %0d, got %0d", s, status);
            errors++;
         end
         if (index !== x) begin
            $error("index: expected %0d, got %0d", x, index);
            errors++;
         end
         if (cnt !== c) begin
            $error("entry_count: expected %0d, got %0d", c, cnt);
            errors++;
         end
      endfunction

      function int pending();
         return exp_status.size();
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic        req_op = 0;
   logic [63:0] req_key = '0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [1:0]  rsp_status;
   logic [7:0]  rsp_index;
   logic [8:0]  rsp_entry_count;
   logic        csr_write = 0;
   logic        csr_index = 0;
   logic [8:0]  csr_data = '0;

   key_table_scoreboard sb = new();
   logic [63:0] known_keys [$];
   int burst_left = 0;
   bit long_hold_req = 0;
   int hold_left = 0;
   bit long_hold_seen = 0;

   sorted_key_table dut (.*);

   initial forever #4 clock = ~clock;

   initial begin
      #40_000_000;
      $display("FAIL");
      $finish;
   end

   // receiver: random stall pattern, plus one long hold-off on request
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_response(rsp_status, rsp_index, rsp_entry_count);
      if (long_hold_req && hold_left == 0) begin
         hold_left = 400;
         long_hold_req = 0;
         long_hold_seen = 1;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 3) == 0);
      end
   end

   task automatic send_item(skt_pkg::op_type op, logic [63:0] key);
      if (burst_left == 0) begin
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = $urandom_range(1, 12);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_key <= key;
      do @(posedge clock); while (req_stall);
      sb.note_request(op, key);
      if (op == skt_pkg::OP_INSERT) known_keys.push_back(key);
      burst_left--;
      if (burst_left == 0) req_valid <= 1'b0;
   endtask

   task automatic drain();
      @(posedge clock);
      req_valid <= 1'b0;
      burst_left = 0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [8:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      sb.write_reg(idx, value);
      @(posedge clock);
   endtask

   function automatic logic [63:0] random_key();
      logic [63:0] k;
      k = {$urandom, $urandom};
      case ($urandom_range(0, 3))
         0: k = k & 64'hF;            // crowd duplicates
         1: k = k & 64'hFFFF;
         default: ;
      endcase
      return k;
   endfunction

   initial begin
      int unsigned caps [10] = '{0, 3, 16, 40, 80, 120, 200, 300, 511, 256};
      logic [63:0] k;
      skt_pkg::op_type op;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      sb.reset_state();
      @(posedge clock);

      // directed: empty search, key extremes, equal keys, full table
      write_csr(skt_pkg::CSR_CAPACITY, 9'd4);
      send_item(skt_pkg::OP_SEARCH, 64'd0);
      send_item(skt_pkg::OP_INSERT, '1);
      send_item(skt_pkg::OP_INSERT, 64'd0);
      send_item(skt_pkg::OP_INSERT, 64'h8000_0000_0000_0000);
      send_item(skt_pkg::OP_INSERT, 64'h8000_0000_0000_0000);
      send_item(skt_pkg::OP_INSERT, 64'd5);
      send_item(skt_pkg::OP_SEARCH, '1);
      send_item(skt_pkg::OP_SEARCH, 64'd0);
      send_item(skt_pkg::OP_SEARCH, 64'h8000_0000_0000_0000);
      send_item(skt_pkg::OP_SEARCH, 64'd7);
      drain();
      // narrow width with entries held: table may fall out of order
      write_csr(skt_pkg::CSR_KEY_WIDTH, 9'(skt_pkg::WM_8));
      write_csr(skt_pkg::CSR_CAPACITY, 9'd6);
      send_item(skt_pkg::OP_SEARCH, 64'h1FF);
      send_item(skt_pkg::OP_INSERT, 64'h1_0003);
      send_item(skt_pkg::OP_SEARCH, 64'h03);
      send_item(skt_pkg::OP_SEARCH, 64'h00);
      drain();
      write_csr(skt_pkg::CSR_CAPACITY, 9'd0);
      send_item(skt_pkg::OP_INSERT, 64'd1);
      send_item(skt_pkg::OP_SEARCH, 64'd5);
      drain();

      for (int ph = 0; ph < 10; ph++) begin
         write_csr(skt_pkg::CSR_KEY_WIDTH,
                   (ph == 9) ? 9'(skt_pkg::WM_64) : 9'($urandom_range(0, 3)));
         write_csr(skt_pkg::CSR_CAPACITY, 9'(caps[ph]));
         if (ph == 5) long_hold_req = 1;
         for (int n = 0; n < 155; n++) begin
            op = ($urandom_range(0, 9) < 4) ? skt_pkg::OP_INSERT : skt_pkg::OP_SEARCH;
            if (op == skt_pkg::OP_SEARCH && known_keys.size() > 0
                && $urandom_range(0, 9) < 6)
               k = known_keys[$urandom_range(0, known_keys.size() - 1)];
            else
               k = random_key();
            send_item(op, k);
         end
         drain();
      end

      $display("covered %0d inserts, %0d search hits, %0d misses, %0d full rejects",
               sb.inserts, sb.hits, sb.misses, sb.fulls);
      $display("final entry count %0d, long receiver hold-off %0s",
               sb.num_keys, long_hold_seen ? "done" : "skipped");
      if (sb.errors == 0 && sb.pending() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end
endmodule
